// ----- design/hsv_to_rgb_led_mixer_assert.svh -----
// Assertion macros shared by the mixer RTL.
`ifndef HSV_TO_RGB_LED_MIXER_ASSERT_SVH
`define HSV_TO_RGB_LED_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HSV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hsv_pkg.sv -----
package hsv_pkg;

    localparam int LEVEL_W  = 8;
    localparam int KIND_W   = 2;
    localparam int SECTOR_W = 3;
    localparam int FRAC_W   = 9;   // g spans 0..256
    localparam int SUM_W    = 17;  // (256-s)*256 + s*g, up to 65536

    localparam logic [KIND_W-1:0] KIND_HUE        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SATURATION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE      = 2'd2;

    localparam logic [SECTOR_W-1:0] SECTOR_RED_UP     = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_TOP  = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_UP    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_DOWN = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_RED_RISE   = 3'd4;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_level;  // take the accepted transaction into the level registers
        logic mul_first;   // hue sector, s*g and v*(256-s)
        logic mul_second;  // v*((256-s)*256 + s*g)
        logic load_result; // channel select into the output register
    } hsv_cmd_t;

endpackage

// ----- design/hsv_ctrl.sv -----
module hsv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hsv_pkg::hsv_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_FIRST,
        ST_MUL_SECOND,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.load_level  = (state_reg == ST_IDLE) && in_valid;
        cmd.mul_first   = (state_reg == ST_MUL_FIRST);
        cmd.mul_second  = (state_reg == ST_MUL_SECOND);
        cmd.load_result = (state_reg == ST_RESULT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces one taken at the same edge
            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_MUL_FIRST;
                end
                ST_MUL_FIRST:
                    state_reg <= ST_MUL_SECOND;
                ST_MUL_SECOND:
                    state_reg <= ST_RESULT;
                ST_RESULT:
                begin
                    // hold until the output register is free
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/hsv_datapath.sv -----
module hsv_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hsv_pkg::hsv_cmd_t                   cmd,
    input  logic [hsv_pkg::KIND_W-1:0]          kind,
    input  logic [hsv_pkg::LEVEL_W-1:0]         new_level,
    output logic [hsv_pkg::LEVEL_W-1:0]         red,
    output logic [hsv_pkg::LEVEL_W-1:0]         green,
    output logic [hsv_pkg::LEVEL_W-1:0]         blue
);

    logic [hsv_pkg::LEVEL_W-1:0]  hue_reg, sat_reg, val_reg;
    logic [hsv_pkg::SECTOR_W-1:0] sector_reg;
    logic [hsv_pkg::FRAC_W-1:0]   inv_sat_reg;
    logic [15:0]                  sg_reg;
    logic [hsv_pkg::LEVEL_W-1:0]  low_reg, mid_reg;
    logic [hsv_pkg::LEVEL_W-1:0]  red_reg, green_reg, blue_reg;

    logic [10:0]                  scaled;
    logic [hsv_pkg::FRAC_W-1:0]   g_frac;
    logic [hsv_pkg::FRAC_W-1:0]   inv_sat;
    logic [16:0]                  sg_prod;
    logic [16:0]                  low_prod;
    logic [hsv_pkg::SUM_W-1:0]    sum;
    logic [24:0]                  mid_prod;

    // stage one: sector, fraction and the two narrow products
    always_comb
    begin
        scaled   = 11'(hue_reg) * 11'd6;
        g_frac   = scaled[8] ? (9'd256 - {1'b0, scaled[7:0]}) : {1'b0, scaled[7:0]};
        inv_sat  = 9'd256 - {1'b0, sat_reg};
        sg_prod  = 17'(sat_reg) * 17'(g_frac);
        low_prod = 17'(val_reg) * 17'(inv_sat);
    end

    // stage two: x channel
    always_comb
    begin
        sum      = {inv_sat_reg, 8'd0} + {1'b0, sg_reg};
        mid_prod = 25'(val_reg) * 25'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
            sat_reg <= '0;
            val_reg <= '0;
        end
        else if (cmd.load_level)
        begin
            unique case (kind)
                hsv_pkg::KIND_HUE:        hue_reg <= new_level;
                hsv_pkg::KIND_SATURATION: sat_reg <= new_level;
                hsv_pkg::KIND_VALUE:      val_reg <= new_level;
                default:                  ;  // unused kind keeps the levels
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_first)
        begin
            sector_reg  <= scaled[10:8];
            inv_sat_reg <= inv_sat;
            sg_reg      <= sg_prod[15:0];
            low_reg     <= low_prod[15:8];
        end
        if (cmd.mul_second)
            mid_reg <= mid_prod[23:16];
        if (cmd.load_result)
        begin
            unique case (sector_reg)
                hsv_pkg::SECTOR_RED_UP:
                begin
                    red_reg <= val_reg; green_reg <= mid_reg; blue_reg <= low_reg;
                end
                hsv_pkg::SECTOR_GREEN_TOP:
                begin
                    red_reg <= mid_reg; green_reg <= val_reg; blue_reg <= low_reg;
                end
                hsv_pkg::SECTOR_BLUE_UP:
                begin
                    red_reg <= low_reg; green_reg <= val_reg; blue_reg <= mid_reg;
                end
                hsv_pkg::SECTOR_GREEN_DOWN:
                begin
                    red_reg <= low_reg; green_reg <= mid_reg; blue_reg <= val_reg;
                end
                hsv_pkg::SECTOR_RED_RISE:
                begin
                    red_reg <= mid_reg; green_reg <= low_reg; blue_reg <= val_reg;
                end
                default:
                begin
                    red_reg <= val_reg; green_reg <= low_reg; blue_reg <= mid_reg;
                end
            endcase
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ----- design/hsv_to_rgb_led_mixer.sv -----
// HSV to RGB LED mixer.
// Input stream (s_axis_*): each transaction writes one 8-bit level. tuser
// carries the kind (0 hue, 1 saturation, 2 value, 3 writes nothing) and
// tdata the new level. Hue is scaled so that 256 is a full turn.
// Output stream (m_axis_*): one transaction per input transaction, carrying
// the red, green and blue drive levels computed from the three held levels.
// An input is accepted, then passes through the sector and narrow-product
// step and the 8x17 multiply, and is loaded into the output register and
// shown on m_axis_tvalid once that register is free. One transaction is
// in work at a time: no new input is taken until the last one is loaded.
// When the receiver stalls, the finished result holds in the output
// register and the next input is still accepted and computed; its result
// waits in the datapath until the output register is taken.
// Reset (rst_n low, asynchronous) clears the three levels to zero, empties
// the output register and returns the controller to idle.
`include "hsv_to_rgb_led_mixer_assert.svh"

module hsv_to_rgb_led_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] new_level
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    hsv_pkg::hsv_cmd_t cmd;

    logic [hsv_pkg::LEVEL_W-1:0] red, green, blue;

    // sequencing and output valid
    hsv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // level registers, multiplies and channel select
    hsv_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (s_axis_tuser),
        .new_level (s_axis_tdata),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_axis_tdata = {blue, green, red};

    // one transaction in work: no back-to-back input acceptance
    `HSV_ASSERT_NEXT(a_single_in_work, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while busy")
    // a new result appears only at the end of a computation
    `HSV_ASSERT_IMPL(a_result_after_work, clk, rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without computation")
    // the datapath never loads a result over one still waiting
    `HSV_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.load_result, !m_axis_tvalid || m_axis_tready, "result overwritten")

endmodule
